>>> design/utlr_pkg.sv
// ----------------------------------------------------------------------------
// utlr_pkg: shared types and constants for the tank level ranger
// Sequencer phases, trigger timing and the per-tick result type.
// ----------------------------------------------------------------------------
package utlr_pkg;

  localparam int unsigned CntW = 17;

  // trigger low lead-in (start tick included) and trigger pulse length
  localparam logic [CntW-1:0] PreLowTicks   = 17'd2;
  localparam logic [CntW-1:0] TrigHighTicks = 17'd20;

  localparam logic [15:0] TankHeightRst  = 16'd1600;
  localparam logic [15:0] EchoTimeoutRst = 16'd40000;

  // register indexes, taken from paddr[2]
  localparam logic RegTankHeight  = 1'b0;
  localparam logic RegEchoTimeout = 1'b1;

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_PRE_LOW   = 3'd1,
    PH_TRIG_HIGH = 3'd2,
    PH_WAIT_RISE = 3'd3,
    PH_MEASURE   = 3'd4
  } phase_t;

  // one tick's result as it leaves the sequencer
  typedef struct packed {
    logic        trig_level;
    logic        busy_res;
    logic        done_res;
    logic        status;
    logic        calc;        // success: level needs computing
    logic [15:0] echo_width;
  } tick_res_t;

endpackage

>>> design/utlr_if.sv
// ----------------------------------------------------------------------------
// utlr_if: valid/ready channels of the tank level ranger
// Input tick channel and result channel, each with source and sink views.
// ----------------------------------------------------------------------------
interface utlr_in_if;
  logic valid;
  logic ready;
  logic start_req;
  logic echo_level;

  modport source (output valid, output start_req, output echo_level, input ready);
  modport sink   (input valid, input start_req, input echo_level, output ready);
endinterface

interface utlr_out_if;
  logic        valid;
  logic        ready;
  logic        trig_level;
  logic        busy_res;
  logic        done_res;
  logic        status;
  logic [15:0] water_level;

  modport source (output valid, output trig_level, output busy_res, output done_res,
                  output status, output water_level, input ready);
  modport sink   (input valid, input trig_level, input busy_res, input done_res,
                  input status, input water_level, output ready);
endinterface

>>> design/utlr_level_calc.sv
// ----------------------------------------------------------------------------
// utlr_level_calc: echo width to clamped water level
// Distance = floor(width * 2^FRAC_BITS / CM_DIVISOR) by reciprocal multiply,
// then level = tank height minus distance, clamped at zero (zero when calc is low).
// ----------------------------------------------------------------------------
module utlr_level_calc #(
  parameter int FRAC_BITS  = 4,
  parameter int CM_DIVISOR = 58
) (
  input  logic        calc,
  input  logic [15:0] echo_width,
  input  logic [15:0] tank_height,
  output logic [15:0] water_level
);
  import utlr_pkg::*;

  localparam int XW = 16 + FRAC_BITS;  // scaled width
  localparam int SH = XW + 8;          // exact for x < 2^XW, divisor < 2^8
  localparam int MW = SH + 1;
  localparam int PW = XW + MW;
  localparam longint RecipL = ((64'd1 << SH) + CM_DIVISOR - 1) / CM_DIVISOR;
  localparam logic [MW-1:0] Recip = MW'(RecipL);

  logic [XW-1:0] scaled;
  logic [PW-1:0] prod;
  logic [XW-1:0] distance;

  assign scaled   = XW'(echo_width) << FRAC_BITS;
  assign prod     = PW'(scaled) * PW'(Recip);
  assign distance = prod[SH+XW-1:SH];

  always_comb begin
    if (!calc || distance >= XW'(tank_height)) begin
      water_level = 16'd0;
    end else begin
      water_level = tank_height - distance[15:0];
    end
  end

endmodule

>>> design/ultrasonic_tank_level_ranger.sv
// ----------------------------------------------------------------------------
// ultrasonic_tank_level_ranger: echo ranging sequencer with level output
// Drives the trigger, times the echo and reports the clamped water level.
// ----------------------------------------------------------------------------
// Usage:
//   in_chan carries one transaction per microsecond tick: start_req and the
//   sampled echo pin level. Each input transaction yields exactly one result
//   transaction on out_chan (trigger level, busy, done, status, water level).
//   Registers (APB, byte address 4*i): tank_height at 0, echo_timeout_ticks
//   at 4. Write them only while the block is idle and drained.
//   Throughput: one transaction per cycle while out_chan is not stalled. The
//   accepting edge updates the sequencer and loads the middle stage; the reciprocal
//   multiply and clamp then feed the output register, which presents the result.
//   Reset clears the sequencer to idle, empties both stages and loads the
//   register defaults (1600, 40000).
//   When out_chan stalls, the output register holds; in_chan keeps taking
//   transactions until the middle stage also fills, then ready drops.
// ----------------------------------------------------------------------------
module ultrasonic_tank_level_ranger #(
  parameter int FRAC_BITS  = 4,
  parameter int CM_DIVISOR = 58
) (
  input  logic                clk,
  input  logic                rst_n,
  utlr_in_if.sink             in_chan,
  utlr_out_if.source          out_chan,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import utlr_pkg::*;

  logic [15:0]     tank_height_r;
  logic [15:0]     echo_timeout_r;
  phase_t          phase_r, phase_nxt;
  logic [CntW-1:0] tick_r, tick_nxt;
  logic [CntW-1:0] tick_inc;
  logic            over_inc;
  logic            over_one;
  tick_res_t       res_nxt;
  tick_res_t       s1_r;
  logic            s1_valid_r;
  logic            out_valid_r;
  logic            out_move;
  logic            in_accept;
  logic [15:0]     level;

  // ---------------- configuration ----------------
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tank_height_r  <= TankHeightRst;
      echo_timeout_r <= EchoTimeoutRst;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        RegTankHeight:  tank_height_r  <= pwdata[15:0];
        RegEchoTimeout: echo_timeout_r <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      RegTankHeight:  prdata = {16'd0, tank_height_r};
      RegEchoTimeout: prdata = {16'd0, echo_timeout_r};
      default:        prdata = 32'd0;
    endcase
  end

  // ---------------- handshake ----------------
  assign out_move      = !out_valid_r || out_chan.ready;
  assign in_chan.ready = !s1_valid_r || out_move;
  assign in_accept     = in_chan.valid && in_chan.ready;

  // ---------------- sequencer ----------------
  assign tick_inc = tick_r + 17'd1;
  assign over_inc = tick_inc > {1'b0, echo_timeout_r};
  assign over_one = (echo_timeout_r == 16'd0);  // a count of one already times out

  always_comb begin
    phase_nxt = phase_r;
    tick_nxt  = tick_r;
    unique case (phase_r)
      PH_IDLE: begin
        if (in_chan.start_req) begin
          phase_nxt = PH_PRE_LOW;
          tick_nxt  = 17'd1;
        end
      end
      PH_PRE_LOW: begin
        tick_nxt = tick_inc;
        if (tick_inc >= PreLowTicks) begin
          phase_nxt = PH_TRIG_HIGH;
          tick_nxt  = '0;
        end
      end
      PH_TRIG_HIGH: begin
        tick_nxt = tick_inc;
        if (tick_inc >= TrigHighTicks) begin
          phase_nxt = PH_WAIT_RISE;
          tick_nxt  = '0;
        end
      end
      PH_WAIT_RISE: begin
        if (in_chan.echo_level) begin
          tick_nxt  = 17'd1;
          phase_nxt = over_one ? PH_IDLE : PH_MEASURE;
        end else begin
          tick_nxt = tick_inc;
          if (over_inc) phase_nxt = PH_IDLE;
        end
      end
      PH_MEASURE: begin
        if (in_chan.echo_level) begin
          tick_nxt = tick_inc;
          if (over_inc) phase_nxt = PH_IDLE;
        end else begin
          phase_nxt = PH_IDLE;
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
        tick_nxt  = '0;
      end
    endcase
  end

  always_comb begin
    res_nxt            = '0;
    res_nxt.busy_res   = 1'b1;
    res_nxt.echo_width = tick_r[15:0];  // at most the timeout on success
    unique case (phase_r)
      PH_IDLE:      res_nxt.busy_res = in_chan.start_req;
      PH_PRE_LOW:   ;
      PH_TRIG_HIGH: res_nxt.trig_level = 1'b1;
      PH_WAIT_RISE: begin
        if ((in_chan.echo_level && over_one) || (!in_chan.echo_level && over_inc)) begin
          res_nxt.busy_res = 1'b0;
          res_nxt.done_res = 1'b1;
          res_nxt.status   = 1'b1;
        end
      end
      PH_MEASURE: begin
        if (in_chan.echo_level) begin
          if (over_inc) begin
            res_nxt.busy_res = 1'b0;
            res_nxt.done_res = 1'b1;
            res_nxt.status   = 1'b1;
          end
        end else begin
          res_nxt.busy_res = 1'b0;
          res_nxt.done_res = 1'b1;
          res_nxt.calc     = 1'b1;
        end
      end
      default:      res_nxt.busy_res = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      tick_r  <= '0;
    end else if (in_accept) begin
      phase_r <= phase_nxt;
      tick_r  <= tick_nxt;
    end
  end

  // ---------------- middle stage ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      s1_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) s1_r <= res_nxt;
  end

  utlr_level_calc #(
    .FRAC_BITS  (FRAC_BITS),
    .CM_DIVISOR (CM_DIVISOR)
  ) u_level_calc (
    .calc        (s1_r.calc),
    .echo_width  (s1_r.echo_width),
    .tank_height (tank_height_r),
    .water_level (level)
  );

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_move) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_move && s1_valid_r) begin
      out_chan.trig_level  <= s1_r.trig_level;
      out_chan.busy_res    <= s1_r.busy_res;
      out_chan.done_res    <= s1_r.done_res;
      out_chan.status      <= s1_r.status;
      out_chan.water_level <= level;
    end
  end

  assign out_chan.valid = out_valid_r;

endmodule
